>>> design/i2c_master_transfer_sequencer_macros.svh
// Assertion macros shared by the sequencer modules.
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_MACROS_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_MACROS_SVH

// Antecedent at one edge, consequent at the next edge.
`define I2CMTS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Antecedent and consequent at the same edge.
`define I2CMTS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> design/i2cmts_pkg.sv
package i2cmts_pkg;

    typedef enum logic [2:0] {
        REQ_LOAD_TX        = 3'd0,
        REQ_START_READ     = 3'd1,
        REQ_START_WRITE    = 3'd2,
        REQ_START_WRITE_SR = 3'd3,
        REQ_BUS_ERROR      = 3'd4,
        REQ_MASTER_ON_BUS  = 3'd5,
        REQ_SLAVE_ON_BUS   = 3'd6
    } req_e;

    typedef enum logic [1:0] {
        ACT_IDLE  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_WRITE = 2'd2
    } act_e;

    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_ADDR    = 3'd1,
        CMD_DATA    = 3'd2,
        CMD_STOP    = 3'd3,
        CMD_RELEASE = 3'd4
    } cmd_e;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BUSY     = 2'd1,
        ST_ZERO_LEN = 2'd2
    } status_e;

    localparam logic [7:0] HS_MASTER_CODE = 8'h08;

    typedef struct packed {
        logic [7:0] done_count;
        logic       transfer_done;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       ack_action;
        logic       hs_address;
        logic [7:0] bus_byte;
        cmd_e       bus_cmd;
        status_e    status;
    } res_t;

endpackage

>>> design/i2cmts_skid.sv
`include "i2c_master_transfer_sequencer_macros.svh"

module i2cmts_skid
    import i2cmts_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  res_t in_item,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_item
);

    logic out_valid_reg;
    res_t out_reg;
    logic skid_valid_reg;
    res_t skid_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_valid;
            end
        end else if (in_valid && in_ready) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready || !out_valid_reg) begin
            out_reg <= skid_valid_reg ? skid_reg : in_item;
        end else if (in_valid && in_ready) begin
            skid_reg <= in_item;
        end
    end

    `I2CMTS_ASSERT_NOW(a_skid_implies_out, aclk, aresetn, skid_valid_reg, out_valid_reg,
        "skid entry held without an output entry")
    `I2CMTS_ASSERT_NEXT(a_skid_drains, aclk, aresetn, skid_valid_reg && out_ready,
        out_valid_reg && (out_reg == $past(skid_reg)), "skid entry not moved to output")

endmodule

>>> design/i2cmts_core.sv
`include "i2c_master_transfer_sequencer_macros.svh"

module i2cmts_core
    import i2cmts_pkg::*;
#(
    parameter int BUF_DEPTH = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr,
    input  logic       cfg_hs_mode,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_req_type,
    input  logic [6:0] s_target_address,
    input  logic [7:0] s_transfer_length,
    input  logic [7:0] s_buffer_index,
    input  logic [7:0] s_tx_data,
    input  logic       s_rx_nack,
    input  logic [7:0] s_rx_data,
    output logic       r_valid,
    input  logic       r_ready,
    output res_t       r_item
);

    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam logic [AW-1:0] PTR_LAST = AW'(BUF_DEPTH - 1);

    logic [7:0] mem [BUF_DEPTH];

    logic          hs_mode_reg;
    act_e          activity_reg, act_next;
    logic [7:0]    byte_count_reg, cnt_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [7:0]    length_reg, len_next;
    logic [7:0]    address_rw_reg, arw_next;
    logic          repeat_start_reg, rs_next;
    logic          nack_set_reg, nack_next;

    logic          s1_valid_reg;
    res_t          s1_reg;
    logic          s1_use_mem_reg;
    logic [7:0]    rd_data_reg;

    res_t          res;
    logic          use_mem;
    logic          mem_wr;
    logic          mem_rd;
    logic          s_accept;
    logic [7:0]    rd_ab;
    logic [7:0]    wr_ab;
    logic [AW-1:0] ptr_inc;

    assign s_ready  = !s1_valid_reg || r_ready;
    assign s_accept = s_valid && s_ready;
    assign rd_ab    = {s_target_address, 1'b1};
    assign wr_ab    = {s_target_address, 1'b0};
    // pointer follows byte_count modulo BUF_DEPTH, also across the 8-bit count wrap
    assign ptr_inc  = ((ptr_reg == PTR_LAST) || (byte_count_reg == 8'hFF)) ? '0
                                                                          : ptr_reg + 1'b1;

    always_comb begin
        act_next  = activity_reg;
        cnt_next  = byte_count_reg;
        ptr_next  = ptr_reg;
        len_next  = length_reg;
        arw_next  = address_rw_reg;
        rs_next   = repeat_start_reg;
        nack_next = nack_set_reg;
        res       = '0;
        use_mem   = 1'b0;
        mem_wr    = 1'b0;
        mem_rd    = 1'b0;
        case (req_e'(s_req_type))
            REQ_LOAD_TX: begin
                mem_wr = ({1'b0, s_buffer_index} < 9'(BUF_DEPTH));
            end
            REQ_START_READ: begin
                if (s_transfer_length == 8'd0) begin
                    res.status = ST_ZERO_LEN;
                end else if (activity_reg != ACT_IDLE) begin
                    res.status = ST_BUSY;
                end else begin
                    arw_next     = rd_ab;
                    len_next     = s_transfer_length;
                    cnt_next     = 8'd0;
                    ptr_next     = '0;
                    act_next     = ACT_READ;
                    nack_next    = (s_transfer_length == 8'd1);
                    res.bus_cmd  = CMD_ADDR;
                    res.bus_byte = hs_mode_reg ? HS_MASTER_CODE : rd_ab;
                end
            end
            REQ_START_WRITE, REQ_START_WRITE_SR: begin
                if (activity_reg != ACT_IDLE) begin
                    res.status = ST_BUSY;
                end else begin
                    rs_next      = (req_e'(s_req_type) == REQ_START_WRITE_SR);
                    arw_next     = wr_ab;
                    len_next     = s_transfer_length;
                    cnt_next     = 8'd0;
                    ptr_next     = '0;
                    act_next     = ACT_WRITE;
                    nack_next    = (s_transfer_length == 8'd1);
                    res.bus_cmd  = CMD_ADDR;
                    res.bus_byte = hs_mode_reg ? HS_MASTER_CODE : wr_ab;
                end
            end
            REQ_BUS_ERROR: begin
                res.bus_cmd       = CMD_STOP;
                act_next          = ACT_IDLE;
                res.transfer_done = 1'b1;
                res.done_count    = byte_count_reg;
            end
            REQ_MASTER_ON_BUS: begin
                if (s_rx_nack) begin
                    if (hs_mode_reg && (address_rw_reg != 8'd0)) begin
                        res.bus_cmd    = CMD_ADDR;
                        res.bus_byte   = address_rw_reg;
                        res.hs_address = 1'b1;
                        arw_next       = 8'd0;
                    end else begin
                        res.bus_cmd       = CMD_STOP;
                        act_next          = ACT_IDLE;
                        res.transfer_done = 1'b1;
                        res.done_count    = byte_count_reg;
                    end
                end else if (byte_count_reg < length_reg) begin
                    res.bus_cmd = CMD_DATA;
                    use_mem     = 1'b1;
                    mem_rd      = 1'b1;
                    cnt_next    = byte_count_reg + 8'd1;
                    ptr_next    = ptr_inc;
                end else begin
                    res.bus_cmd       = repeat_start_reg ? CMD_RELEASE : CMD_STOP;
                    rs_next           = 1'b0;
                    act_next          = ACT_IDLE;
                    res.transfer_done = 1'b1;
                    res.done_count    = byte_count_reg;
                end
            end
            REQ_SLAVE_ON_BUS: begin
                res.rx_valid = 1'b1;
                res.rx_byte  = s_rx_data;
                cnt_next     = byte_count_reg + 8'd1;
                ptr_next     = ptr_inc;
                if (nack_set_reg) begin
                    res.bus_cmd       = CMD_STOP;
                    act_next          = ACT_IDLE;
                    res.transfer_done = 1'b1;
                    res.done_count    = length_reg;
                end else if (({1'b0, byte_count_reg} + 9'd1) >= {1'b0, length_reg}) begin
                    nack_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
        res.ack_action = nack_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hs_mode_reg      <= 1'b0;
            activity_reg     <= ACT_IDLE;
            byte_count_reg   <= 8'd0;
            ptr_reg          <= '0;
            length_reg       <= 8'd0;
            address_rw_reg   <= 8'd0;
            repeat_start_reg <= 1'b0;
            nack_set_reg     <= 1'b0;
            s1_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr) begin
                hs_mode_reg <= cfg_hs_mode;
            end
            if (s_accept) begin
                activity_reg     <= act_next;
                byte_count_reg   <= cnt_next;
                ptr_reg          <= ptr_next;
                length_reg       <= len_next;
                address_rw_reg   <= arw_next;
                repeat_start_reg <= rs_next;
                nack_set_reg     <= nack_next;
                s1_valid_reg     <= 1'b1;
            end else if (r_ready) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_reg         <= res;
            s1_use_mem_reg <= use_mem;
        end
    end

    // transmit buffer: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (s_accept && mem_wr) begin
            mem[s_buffer_index[AW-1:0]] <= s_tx_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && mem_rd) begin
            rd_data_reg <= mem[ptr_reg];
        end
    end

    always_comb begin
        r_item = s1_reg;
        if (s1_use_mem_reg) begin
            r_item.bus_byte = rd_data_reg;
        end
    end

    assign r_valid = s1_valid_reg;

    `I2CMTS_ASSERT_NEXT(a_done_goes_idle, aclk, aresetn, s_accept && res.transfer_done,
        activity_reg == ACT_IDLE, "completed transfer left sequencer active")
    `I2CMTS_ASSERT_NEXT(a_busy_holds_state, aclk, aresetn, s_accept && (res.status == ST_BUSY),
        $stable(activity_reg) && $stable(length_reg) && $stable(byte_count_reg),
        "rejected start changed transfer state")
    `I2CMTS_ASSERT_NEXT(a_hs_addr_clears, aclk, aresetn, s_accept && res.hs_address,
        address_rw_reg == 8'd0, "address byte not cleared after high-speed address")
    `I2CMTS_ASSERT_NOW(a_ptr_in_range, aclk, aresetn, 1'b1, 32'(ptr_reg) < BUF_DEPTH,
        "buffer pointer beyond buffer depth")

endmodule

>>> design/i2c_master_transfer_sequencer.sv
// I2C master transfer sequencer.
// Input channel s_*: one event per transfer, kind in s_tuser. Start requests set up a
// read or write and return the first bus command (address byte, or master code in
// high-speed mode); master_on_bus and slave_on_bus events then step the transfer.
// load_tx events fill the transmit buffer (BUF_DEPTH bytes, block RAM style).
// Result channel m_*: exactly one result per event, in order.
// Configuration channel cfg_*: hs_mode in cfg_data, written by the user only while
// the block is idle; the block itself does not enforce this. A result passes the
// core result register (with the buffer read), then the skid stage output register.
// Throughput: one event per cycle while not stalled; buffer reads one byte a cycle.
// Reset (aresetn low, synchronous): transfer state idle, hs_mode 0, no results
// pending. Buffer contents are not cleared; sending an unwritten entry gives junk.
// Stall: when m_tready is low up to three results are held (output register, skid
// entry, core register), then s_tready drops until results drain; nothing is lost.
module i2c_master_transfer_sequencer
    import i2cmts_pkg::*;
#(
    parameter int BUF_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,    // hs_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    // target_address[6:0], transfer_length[14:7], buffer_index[22:15],
    // tx_data[30:23], rx_nack[31], rx_data[39:32]
    input  logic [39:0] s_tdata,
    input  logic [2:0]  s_tuser,     // req_type[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], bus_cmd[4:2], bus_byte[12:5], hs_address[13], ack_action[14],
    // rx_valid[15], rx_byte[23:16], transfer_done[24], done_count[32:25], zero[39:33]
    output logic [39:0] m_tdata
);

    logic r_valid;
    logic r_ready;
    res_t r_item;
    res_t out_item;

    assign cfg_ready = 1'b1;

    i2cmts_core #(
        .BUF_DEPTH(BUF_DEPTH)
    ) u_core (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr            (cfg_valid && cfg_ready),
        .cfg_hs_mode       (cfg_data),
        .s_valid           (s_tvalid),
        .s_ready           (s_tready),
        .s_req_type        (s_tuser),
        .s_target_address  (s_tdata[6:0]),
        .s_transfer_length (s_tdata[14:7]),
        .s_buffer_index    (s_tdata[22:15]),
        .s_tx_data         (s_tdata[30:23]),
        .s_rx_nack         (s_tdata[31]),
        .s_rx_data         (s_tdata[39:32]),
        .r_valid           (r_valid),
        .r_ready           (r_ready),
        .r_item            (r_item)
    );

    i2cmts_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (r_valid),
        .in_ready  (r_ready),
        .in_item   (r_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    assign m_tdata = {7'd0, out_item.done_count, out_item.transfer_done, out_item.rx_byte,
                      out_item.rx_valid, out_item.ack_action, out_item.hs_address,
                      out_item.bus_byte, out_item.bus_cmd, out_item.status};

endmodule

>>> tb/sv/i2c_master_transfer_sequencer_tb.sv
`timescale 1ns / 100ps

module i2c_master_transfer_sequencer_tb
    import i2cmts_pkg::*;
;

    typedef struct {
        logic [2:0] req;
        logic [6:0] addr;
        logic [7:0] len;
        logic [7:0] idx;
        logic [7:0] txd;
        logic       nack;
        logic [7:0] rxd;
    } seq_event_t;

    class sequencer_scoreboard;
        logic       hs_mode;
        act_e       activity;
        logic [7:0] byte_count;
        logic [7:0] length_reg;
        logic [7:0] address_rw;
        logic       repeat_start;
        logic       nack_set;
        logic [7:0] tx_buffer [256];
        bit         loaded [256];
        res_t       expected_results [$];
        int         mismatches;

        function new();
            hs_mode      = 1'b0;
            activity     = ACT_IDLE;
            byte_count   = 8'd0;
            length_reg   = 8'd0;
            address_rw   = 8'd0;
            repeat_start = 1'b0;
            nack_set     = 1'b0;
            mismatches   = 0;
        endfunction

        function logic [7:0] open_transfer(logic [7:0] addr_byte, logic [7:0] len, act_e act);
            address_rw = addr_byte;
            length_reg = len;
            byte_count = 8'd0;
            activity   = act;
            nack_set   = (len == 8'd1);
            return hs_mode ? HS_MASTER_CODE : addr_byte;
        endfunction

        function void close_transfer(inout res_t r, input logic [7:0] cnt);
            activity        = ACT_IDLE;
            r.transfer_done = 1'b1;
            r.done_count    = cnt;
        endfunction

        function res_t predict_result(seq_event_t e);
            res_t r;
            r = '0;
            case (e.req)
                REQ_LOAD_TX: begin
                    tx_buffer[e.idx] = e.txd;
                    loaded[e.idx]    = 1'b1;
                end
                REQ_START_READ: begin
                    if (e.len == 8'd0) begin
                        r.status = ST_ZERO_LEN;
                    end else if (activity != ACT_IDLE) begin
                        r.status = ST_BUSY;
                    end else begin
                        r.bus_cmd  = CMD_ADDR;
                        r.bus_byte = open_transfer({e.addr, 1'b1}, e.len, ACT_READ);
                    end
                end
                REQ_START_WRITE, REQ_START_WRITE_SR: begin
                    if (activity != ACT_IDLE) begin
                        r.status = ST_BUSY;
                    end else begin
                        repeat_start = (e.req == REQ_START_WRITE_SR);
                        r.bus_cmd    = CMD_ADDR;
                        r.bus_byte   = open_transfer({e.addr, 1'b0}, e.len, ACT_WRITE);
                    end
                end
                REQ_BUS_ERROR: begin
                    r.bus_cmd = CMD_STOP;
                    close_transfer(r, byte_count);
                end
                REQ_MASTER_ON_BUS: begin
                    if (e.nack) begin
                        // hs: NACK of the master code, now send the real address
                        if (hs_mode && address_rw != 8'd0) begin
                            r.bus_cmd    = CMD_ADDR;
                            r.bus_byte   = address_rw;
                            r.hs_address = 1'b1;
                            address_rw   = 8'd0;
                        end else begin
                            r.bus_cmd = CMD_STOP;
                            close_transfer(r, byte_count);
                        end
                    end else if (byte_count < length_reg) begin
                        r.bus_cmd  = CMD_DATA;
                        r.bus_byte = tx_buffer[byte_count];
                        byte_count++;
                    end else begin
                        r.bus_cmd    = repeat_start ? CMD_RELEASE : CMD_STOP;
                        repeat_start = 1'b0;
                        close_transfer(r, byte_count);
                    end
                end
                REQ_SLAVE_ON_BUS: begin
                    r.rx_valid = 1'b1;
                    r.rx_byte  = e.rxd;
                    if (nack_set) begin
                        r.bus_cmd = CMD_STOP;
                        byte_count++;
                        close_transfer(r, length_reg);
                    end else begin
                        if ({1'b0, byte_count} + 9'd1 >= {1'b0, length_reg})
                            nack_set = 1'b1;
                        byte_count++;
                    end
                end
                default: ;
            endcase
            r.ack_action = nack_set;
            return r;
        endfunction

        // true when this event would send a buffer entry never loaded
        function bit needs_load(seq_event_t e, output logic [7:0] slot);
            slot = byte_count;
            return e.req == REQ_MASTER_ON_BUS && !e.nack && byte_count < length_reg
                && !loaded[byte_count];
        endfunction

        function void note_event(seq_event_t e);
            expected_results.push_back(predict_result(e));
        endfunction

        task flag_mismatch(string msg);
            mismatches++;
            if (mismatches <= 40)
                $display("%0t mismatch: %s", $time, msg);
        endtask

        task compare_field(string name, int unsigned got, int unsigned want);
            if (got != want)
                flag_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        endtask

        task check_result(logic [39:0] d);
            res_t got;
            res_t want;
            got = d[32:0];
            if (expected_results.size() == 0) begin
                flag_mismatch($sformatf("result %h with nothing expected", d));
                return;
            end
            want = expected_results.pop_front();
            compare_field("status", got.status, want.status);
            compare_field("bus_cmd", got.bus_cmd, want.bus_cmd);
            compare_field("bus_byte", got.bus_byte, want.bus_byte);
            compare_field("hs_address", got.hs_address, want.hs_address);
            compare_field("ack_action", got.ack_action, want.ack_action);
            compare_field("rx_valid", got.rx_valid, want.rx_valid);
            compare_field("rx_byte", got.rx_byte, want.rx_byte);
            compare_field("transfer_done", got.transfer_done, want.transfer_done);
            compare_field("done_count", got.done_count, want.done_count);
            compare_field("pad", d[39:33], 0);
        endtask
    endclass

    localparam int          IDLE_LIMIT  = 5000;
    localparam int          PHASE_ITEMS = 300;
    localparam logic [5:0]  PHASE_HS    = 6'b011010;
    localparam logic [2:0]  REQ_UNUSED  = 3'd7;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data  = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;
    logic [2:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;

    sequencer_scoreboard sb = new();

    int burst_left   = 1;
    int n_sent       = 0;
    bit steady       = 1'b0;
    int ready_left   = 0;
    int stall_roll   = 0;
    int quiet_cycles = 0;

    i2c_master_transfer_sequencer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic seq_event_t make_event(logic [2:0] req, logic [6:0] addr,
                                              logic [7:0] len, logic [7:0] idx,
                                              logic [7:0] txd, logic nack, logic [7:0] rxd);
        seq_event_t e;
        e.req  = req;
        e.addr = addr;
        e.len  = len;
        e.idx  = idx;
        e.txd  = txd;
        e.nack = nack;
        e.rxd  = rxd;
        return e;
    endfunction

    function automatic seq_event_t random_event();
        seq_event_t e;
        e.req  = 3'($urandom);
        e.addr = 7'($urandom);
        e.len  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
        e.idx  = 8'($urandom);
        e.txd  = 8'($urandom);
        e.nack = 1'($urandom);
        e.rxd  = 8'($urandom);
        return e;
    endfunction

    function automatic seq_event_t with_kind(logic [2:0] req, logic nack);
        seq_event_t e;
        e      = random_event();
        e.req  = req;
        e.nack = nack;
        return e;
    endfunction

    task automatic send_event(seq_event_t e);
        s_tvalid <= 1'b1;
        s_tuser  <= e.req;
        s_tdata  <= {e.rxd, e.nack, e.txd, e.idx, e.len, e.addr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_event(e);
        n_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            if (!steady && $urandom_range(0, 9) < 7) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 20 : 4))
                    @(posedge aclk);
            end
        end
    endtask

    task automatic issue(seq_event_t e);
        logic [7:0] slot;
        if (sb.needs_load(e, slot))
            send_event(make_event(REQ_LOAD_TX, 7'd0, 8'd0, slot, 8'($urandom), 1'b0, 8'd0));
        send_event(e);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic run_transfer(bit rd, logic [7:0] len);
        seq_event_t e;
        logic [2:0] kind;
        int         roll;
        int         beats;
        kind = rd ? REQ_START_READ
                  : ($urandom_range(0, 1) ? REQ_START_WRITE_SR : REQ_START_WRITE);
        e     = with_kind(kind, 1'($urandom));
        e.len = len;
        issue(e);
        if (sb.hs_mode && sb.activity != ACT_IDLE && $urandom_range(0, 99) < 85)
            issue(with_kind(REQ_MASTER_ON_BUS, 1'b1));
        beats = 0;
        while (sb.activity != ACT_IDLE && beats < 400) begin
            roll = $urandom_range(0, 99);
            beats++;
            if (roll < 3)
                issue(with_kind(REQ_BUS_ERROR, 1'($urandom)));
            else if (roll < 8)
                issue(with_kind(3'($urandom_range(1, 3)), 1'($urandom)));
            else if (rd)
                issue(with_kind(REQ_SLAVE_ON_BUS, 1'($urandom)));
            else
                issue(with_kind(REQ_MASTER_ON_BUS, roll < 11));
        end
    endtask

    // receiver backpressure
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
        if (steady) begin
            m_tready <= 1'b1;
        end else if (ready_left > 0) begin
            ready_left = ready_left - 1;
        end else begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 50) begin
                m_tready <= 1'b1;
                ready_left = $urandom_range(0, 40);
            end else if (stall_roll < 85) begin
                m_tready <= 1'b0;
                ready_left = $urandom_range(0, 5);
            end else begin
                m_tready <= 1'b0;
                ready_left = $urandom_range(10, 30);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("i2c_master_transfer_sequencer test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int         roll;
        int         target;
        logic [7:0] len;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        for (int p = 0; p < 6; p++) begin
            settle();
            cfg_valid <= 1'b1;
            cfg_data  <= PHASE_HS[p];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            cfg_valid <= 1'b0;
            sb.hs_mode = PHASE_HS[p];
            steady     = (p == 3);

            if (p == 0) begin
                issue(make_event(REQ_START_READ, 7'h7F, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0));
                issue(make_event(REQ_LOAD_TX, 7'd0, 8'd0, 8'd0, 8'hFF, 1'b0, 8'd0));
                issue(make_event(REQ_LOAD_TX, 7'd0, 8'd0, 8'hFF, 8'h00, 1'b0, 8'd0));
                issue(make_event(REQ_LOAD_TX, 7'd0, 8'd0, 8'd1, 8'h5A, 1'b0, 8'd0));
                issue(make_event(REQ_START_WRITE, 7'd0, 8'd2, 8'd0, 8'd0, 1'b0, 8'd0));
                // busy, then zero length wins over busy
                issue(make_event(REQ_START_READ, 7'h2A, 8'hFF, 8'd0, 8'd0, 1'b0, 8'd0));
                issue(make_event(REQ_START_READ, 7'h2A, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0));
                issue(make_event(REQ_START_WRITE_SR, 7'h11, 8'd4, 8'd0, 8'd0, 1'b0, 8'd0));
                repeat (3)
                    issue(make_event(REQ_MASTER_ON_BUS, 7'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0));
                // zero length write ending in release
                issue(make_event(REQ_START_WRITE_SR, 7'h7F, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0));
                issue(make_event(REQ_MASTER_ON_BUS, 7'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0));
                issue(make_event(REQ_START_READ, 7'h55, 8'd1, 8'd0, 8'd0, 1'b0, 8'd0));
                issue(make_event(REQ_SLAVE_ON_BUS, 7'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'hFF));
                issue(make_event(REQ_START_WRITE, 7'h05, 8'd3, 8'd0, 8'd0, 1'b0, 8'd0));
                issue(make_event(REQ_MASTER_ON_BUS, 7'd0, 8'd0, 8'd0, 8'd0, 1'b1, 8'd0));
                issue(make_event(REQ_UNUSED, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF));
                // bus events while idle
                issue(make_event(REQ_BUS_ERROR, 7'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0));
                issue(make_event(REQ_MASTER_ON_BUS, 7'd0, 8'd0, 8'd0, 8'd0, 1'b1, 8'd0));
                issue(make_event(REQ_SLAVE_ON_BUS, 7'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'h00));
            end
            if (p == 1) begin
                issue(make_event(REQ_START_WRITE, 7'h10, 8'd1, 8'd0, 8'd0, 1'b0, 8'd0));
                issue(make_event(REQ_MASTER_ON_BUS, 7'd0, 8'd0, 8'd0, 8'd0, 1'b1, 8'd0));
                repeat (2)
                    issue(make_event(REQ_MASTER_ON_BUS, 7'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0));
                // address 0 in hs mode falls through to the plain NACK stop
                issue(make_event(REQ_START_WRITE, 7'd0, 8'd1, 8'd0, 8'd0, 1'b0, 8'd0));
                issue(make_event(REQ_MASTER_ON_BUS, 7'd0, 8'd0, 8'd0, 8'd0, 1'b1, 8'd0));
                // full length read, then a bus error reports its byte_count
                run_transfer(1'b1, 8'd255);
                issue(with_kind(REQ_BUS_ERROR, 1'b0));
            end

            target = n_sent + PHASE_ITEMS;
            while (n_sent < target) begin
                roll = $urandom_range(0, 99);
                if (roll < 60) begin
                    roll = $urandom_range(0, 99);
                    len  = (roll < 2) ? 8'd255
                         : (roll < 6) ? 8'($urandom) : 8'($urandom_range(0, 8));
                    run_transfer(1'($urandom), len);
                end else if (roll < 75) begin
                    repeat ($urandom_range(1, 6)) issue(with_kind(REQ_LOAD_TX, 1'($urandom)));
                end else begin
                    repeat ($urandom_range(1, 4)) issue(random_event());
                end
            end
        end
        settle();
        if (sb.mismatches == 0)
            $display("i2c_master_transfer_sequencer test passed");
        else
            $display("i2c_master_transfer_sequencer test failed");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+design
design/i2cmts_pkg.sv
design/i2cmts_skid.sv
design/i2cmts_core.sv
design/i2c_master_transfer_sequencer.sv
tb/sv/i2c_master_transfer_sequencer_tb.sv
